/* rtl/idq_pkg.sv */
// Package for the indexed double-ended queue.
// Holds request and status codes, field widths and parameter defaults.
// No dependencies.
package idq_pkg;

    localparam int unsigned CAPACITY_DEF  = 1024;
    localparam int unsigned WORD_BITS_DEF = 32;

    localparam int unsigned FUNC_W = 4;
    localparam int unsigned POS_W  = 11;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned OCC_W  = 11;

    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 4'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 4'd1;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 4'd2;
    localparam logic [FUNC_W-1:0] FN_POP_BACK   = 4'd3;
    localparam logic [FUNC_W-1:0] FN_INSERT     = 4'd4;
    localparam logic [FUNC_W-1:0] FN_REMOVE     = 4'd5;
    localparam logic [FUNC_W-1:0] FN_READ       = 4'd6;
    localparam logic [FUNC_W-1:0] FN_CLEAR      = 4'd7;
    localparam logic [FUNC_W-1:0] FN_REVERSE    = 4'd8;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

endpackage

/* rtl/idq_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module idq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

/* rtl/indexed_double_ended_queue_top.sv */
// Top level of the indexed double-ended queue.
// Depends on idq_pkg and idq_ram.
//
// Usage:
//   Requests enter on the s_axis channel: tuser carries the request code,
//   tdata the logical position and the word to push or insert. Each
//   request gives exactly one result on the m_axis channel: tuser carries
//   the status, tdata the word read out and the new occupancy.
//   Words live in one RAM of CAPACITY entries with a registered
//   read; head and count are registers. Requests are processed one at a time.
//   Insert and remove shift the words between the index and one end of
//   the queue, one word per cycle; reverse reads and then writes back
//   each swapped pair through the single read and write ports.
//   The result sits in an output register, so a new request is accepted
//   while an earlier result still waits; if the receiver stalls, the next
//   result waits in the finishing state until the output register frees.
//   Reset empties the queue (count zero, head in the middle of the store);
//   RAM contents are not cleared and are never read before being written.
module indexed_double_ended_queue_top
    import idq_pkg::*;
#(
    parameter int unsigned CAPACITY  = CAPACITY_DEF,
    parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [10:0] position, [42:11] data_in, rest zero
    input  logic [3:0]  s_axis_tuser,   // [3:0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [31:0] data_out, [42:32] occupancy, rest zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned XW = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam logic [AW-1:0] MID = AW'(CAPACITY / 2);
    localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);
    localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_SHIFT = 4'd3;
    localparam logic [3:0] S_FIN   = 4'd4;
    localparam logic [3:0] S_RA    = 4'd5;
    localparam logic [3:0] S_RB    = 4'd6;
    localparam logic [3:0] S_WA    = 4'd7;
    localparam logic [3:0] S_WB    = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] a);
        return (a == LAST) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [AW-1:0] f_dec(input logic [AW-1:0] a);
        return (a == '0) ? LAST : a - 1'b1;
    endfunction

    // Physical slot of a logical index; head plus index stays below twice the capacity.
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] h, input logic [XW-1:0] x);
        logic [XW-1:0] s;
        s = XW'(h) + x;
        if (s >= CAP_X) begin
            s = s - CAP_X;
        end
        return s[AW-1:0];
    endfunction

    // Control and payload registers
    logic [3:0]           r_state, n_state;
    logic [AW-1:0]        r_head, n_head;
    logic [CW-1:0]        r_stored, n_stored;
    logic [FUNC_W-1:0]    r_func, n_func;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic [DATA_W-1:0]    r_din, n_din;
    logic [STAT_W-1:0]    r_status, n_status;
    logic [WORD_BITS-1:0] r_dout, n_dout;
    logic [WORD_BITS-1:0] r_tmp, n_tmp;
    logic [AW-1:0]        r_src, n_src;      // shift read pointer, or low end of reverse
    logic [AW-1:0]        r_hi, n_hi;        // high end of reverse
    logic [AW-1:0]        r_wdst, n_wdst;    // pending shift write target
    logic [AW-1:0]        r_fin, n_fin;      // final insert slot
    logic                 r_wv, n_wv;
    logic                 r_dir, n_dir;      // 1: walk toward higher slots
    logic [CW-1:0]        r_cnt, n_cnt;
    logic                 r_m_valid, n_m_valid;
    logic [STAT_W-1:0]    r_m_status, n_m_status;
    logic [DATA_W-1:0]    r_m_dout, n_m_dout;
    logic [OCC_W-1:0]     r_m_occ, n_m_occ;

    // RAM port signals
    logic                 w_we, w_re;
    logic [AW-1:0]        w_waddr, w_raddr;
    logic [WORD_BITS-1:0] w_wdata, w_rdata;

    // Decode helpers
    logic [XW-1:0]        w_n, w_posx, w_half;
    logic [AW-1:0]        w_pp, w_pn, w_pn1;
    logic                 w_full, w_empty, w_one;
    logic [WORD_BITS-1:0] w_word_in;
    logic [DATA_W-1:0]    w_dout_ext;
    logic [XW-1:0]        w_occ_x;

    idq_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Resize the word between the port width and the stored width.
    always_comb begin
        w_word_in  = '0;
        w_dout_ext = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (i < DATA_W) begin
                w_word_in[i]  = r_din[i];
                w_dout_ext[i] = r_dout[i];
            end
        end
    end

    assign w_n     = XW'(r_stored);
    assign w_posx  = XW'(r_pos);
    assign w_half  = w_n >> 1;
    assign w_pp    = f_phys(r_head, w_posx);
    assign w_pn    = f_phys(r_head, w_n);
    assign w_pn1   = f_dec(w_pn);
    assign w_full  = (w_n == CAP_X);
    assign w_empty = (r_stored == '0);
    assign w_one   = (w_n == XW'(1));
    assign w_occ_x = XW'(r_stored);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tdata  = {5'b0, r_m_occ, r_m_dout};

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_stored   = r_stored;
        n_func     = r_func;
        n_pos      = r_pos;
        n_din      = r_din;
        n_status   = r_status;
        n_dout     = r_dout;
        n_tmp      = r_tmp;
        n_src      = r_src;
        n_hi       = r_hi;
        n_wdst     = r_wdst;
        n_fin      = r_fin;
        n_wv       = r_wv;
        n_dir      = r_dir;
        n_cnt      = r_cnt;
        n_m_valid  = r_m_valid;
        n_m_status = r_m_status;
        n_m_dout   = r_m_dout;
        n_m_occ    = r_m_occ;
        w_we       = 1'b0;
        w_waddr    = '0;
        w_wdata    = '0;
        w_re       = 1'b0;
        w_raddr    = '0;

        // Drop the posted result once taken.
        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_func  = s_axis_tuser;
                    n_pos   = s_axis_tdata[POS_W-1:0];
                    n_din   = s_axis_tdata[POS_W+DATA_W-1:POS_W];
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_status = ST_OK;
                n_dout   = '0;
                n_state  = S_DONE;
                case (r_func)
                    FN_PUSH_FRONT: begin
                        if (w_full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_head   = f_dec(r_head);
                            w_we     = 1'b1;
                            w_waddr  = f_dec(r_head);
                            w_wdata  = w_word_in;
                            n_stored = r_stored + 1'b1;
                        end
                    end
                    FN_PUSH_BACK: begin
                        if (w_full) begin
                            n_status = ST_FULL;
                        end else begin
                            w_we     = 1'b1;
                            w_waddr  = w_pn;
                            w_wdata  = w_word_in;
                            n_stored = r_stored + 1'b1;
                        end
                    end
                    FN_POP_FRONT: begin
                        if (w_empty) begin
                            n_status = ST_BAD;
                        end else begin
                            w_re     = 1'b1;
                            w_raddr  = r_head;
                            n_head   = w_one ? MID : f_inc(r_head);
                            n_stored = r_stored - 1'b1;
                            n_state  = S_RD;
                        end
                    end
                    FN_POP_BACK: begin
                        if (w_empty) begin
                            n_status = ST_BAD;
                        end else begin
                            w_re     = 1'b1;
                            w_raddr  = w_pn1;
                            n_head   = w_one ? MID : r_head;
                            n_stored = r_stored - 1'b1;
                            n_state  = S_RD;
                        end
                    end
                    FN_INSERT: begin
                        if (w_posx > w_n) begin
                            n_status = ST_BAD;
                        end else if (w_full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_stored = r_stored + 1'b1;
                            n_wv     = 1'b0;
                            n_state  = S_SHIFT;
                            if (w_posx < w_half) begin
                                // Grow at the front: move the leading words down one slot.
                                n_head = f_dec(r_head);
                                n_src  = r_head;
                                n_dir  = 1'b1;
                                n_cnt  = CW'(w_posx);
                                n_fin  = f_dec(w_pp);
                            end else begin
                                // Grow at the back: move the trailing words up one slot.
                                n_src  = w_pn1;
                                n_dir  = 1'b0;
                                n_cnt  = CW'(w_n - w_posx);
                                n_fin  = w_pp;
                            end
                        end
                    end
                    FN_REMOVE: begin
                        if (w_posx >= w_n) begin
                            n_status = ST_BAD;
                        end else begin
                            w_re     = 1'b1;
                            w_raddr  = w_pp;
                            n_stored = r_stored - 1'b1;
                            n_wv     = 1'b0;
                            n_state  = S_RD;
                            if (w_posx < w_half) begin
                                n_src  = f_dec(w_pp);
                                n_dir  = 1'b0;
                                n_cnt  = CW'(w_posx);
                                n_head = f_inc(r_head);
                            end else begin
                                n_src  = f_inc(w_pp);
                                n_dir  = 1'b1;
                                n_cnt  = CW'(w_n - w_posx - XW'(1));
                                n_head = w_one ? MID : r_head;
                            end
                        end
                    end
                    FN_READ: begin
                        if (w_posx >= w_n) begin
                            n_status = ST_BAD;
                        end else begin
                            w_re    = 1'b1;
                            w_raddr = w_pp;
                            n_state = S_RD;
                        end
                    end
                    FN_CLEAR: begin
                        n_head   = MID;
                        n_stored = '0;
                    end
                    FN_REVERSE: begin
                        if (w_n >= XW'(2)) begin
                            n_src   = r_head;
                            n_hi    = w_pn1;
                            n_cnt   = CW'(w_half);
                            n_state = S_RA;
                        end
                    end
                    default: begin
                        n_status = ST_BAD;
                    end
                endcase
            end
            S_RD: begin
                n_dout  = w_rdata;
                n_state = (r_func == FN_REMOVE) ? S_SHIFT : S_DONE;
            end
            S_SHIFT: begin
                // Write the word read last cycle while reading the next one.
                if (r_wv) begin
                    w_we    = 1'b1;
                    w_waddr = r_wdst;
                    w_wdata = w_rdata;
                end
                if (r_cnt != '0) begin
                    w_re    = 1'b1;
                    w_raddr = r_src;
                    n_wv    = 1'b1;
                    n_wdst  = r_dir ? f_dec(r_src) : f_inc(r_src);
                    n_src   = r_dir ? f_inc(r_src) : f_dec(r_src);
                    n_cnt   = r_cnt - 1'b1;
                end else begin
                    n_wv = 1'b0;
                    if (!r_wv) begin
                        n_state = (r_func == FN_INSERT) ? S_FIN : S_DONE;
                    end
                end
            end
            S_FIN: begin
                w_we    = 1'b1;
                w_waddr = r_fin;
                w_wdata = w_word_in;
                n_state = S_DONE;
            end
            S_RA: begin
                w_re    = 1'b1;
                w_raddr = r_src;
                n_state = S_RB;
            end
            S_RB: begin
                w_re    = 1'b1;
                w_raddr = r_hi;
                n_tmp   = w_rdata;
                n_state = S_WA;
            end
            S_WA: begin
                w_we    = 1'b1;
                w_waddr = r_src;
                w_wdata = w_rdata;
                n_state = S_WB;
            end
            S_WB: begin
                w_we    = 1'b1;
                w_waddr = r_hi;
                w_wdata = r_tmp;
                n_src   = f_inc(r_src);
                n_hi    = f_dec(r_hi);
                n_cnt   = r_cnt - 1'b1;
                n_state = (r_cnt == CW'(1)) ? S_DONE : S_RA;
            end
            S_DONE: begin
                // Hold here until the output register is free.
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid  = 1'b1;
                    n_m_status = r_status;
                    n_m_dout   = w_dout_ext;
                    n_m_occ    = w_occ_x[OCC_W-1:0];
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= MID;
            r_stored  <= '0;
            r_m_valid <= 1'b0;
            r_wv      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_stored  <= n_stored;
            r_m_valid <= n_m_valid;
            r_wv      <= n_wv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_pos      <= n_pos;
        r_din      <= n_din;
        r_status   <= n_status;
        r_dout     <= n_dout;
        r_tmp      <= n_tmp;
        r_src      <= n_src;
        r_hi       <= n_hi;
        r_wdst     <= n_wdst;
        r_fin      <= n_fin;
        r_dir      <= n_dir;
        r_cnt      <= n_cnt;
        r_m_status <= n_m_status;
        r_m_dout   <= n_m_dout;
        r_m_occ    <= n_m_occ;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_stored) <= CAP_X)
        else $error("stored count exceeds capacity");

    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && w_re) |-> (w_waddr != w_raddr))
        else $error("RAM read and write hit the same slot");

    a_empty_head_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_stored == '0) |-> (r_head == MID))
        else $error("empty queue with head off the middle");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_head) < CAP_X)
        else $error("head pointer out of range");
`endif

endmodule

/* dv/tb_indexed_double_ended_queue_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for indexed_double_ended_queue_top.
// Depends on idq_pkg and the RTL top; predicts each result with a local queue model.
module tb_indexed_double_ended_queue_top;
    import idq_pkg::*;

    localparam int unsigned DEPTH   = CAPACITY_DEF;
    localparam int unsigned N_RAND  = 627;
    localparam int unsigned WD_MAX  = 20000;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [31:0]       data_out;
        logic [OCC_W-1:0]  occupancy;
    } t_idq_result;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [POS_W-1:0]  position;
        logic [31:0]       data_in;
        bit                has_exp;
        t_idq_result       exp;
    } t_idq_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // [10:0] position, [42:11] data_in, rest zero
    logic [3:0]  s_axis_tuser;   // [3:0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // [31:0] data_out, [42:32] occupancy, rest zero
    logic [1:0]  m_axis_tuser;   // [1:0] status

    indexed_double_ended_queue_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Shadow of the queue: a plain logical array, front at index 0.
    logic [31:0] shadow_words [$];
    t_idq_result pending_results [$];
    int unsigned fail_count = 0;
    int unsigned sent_count = 0;
    int unsigned recv_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned send_idle_pct = 21;
    int unsigned recv_idle_pct = 46;
    int unsigned max_occ_seen = 0;

    // Apply one request to the shadow and return the result it should produce.
    function automatic t_idq_result predict_request(input logic [FUNC_W-1:0] fn,
                                                    input logic [POS_W-1:0] pos,
                                                    input logic [31:0] din);
        t_idq_result r;
        int unsigned n;
        n = shadow_words.size();
        r.status   = ST_OK;
        r.data_out = '0;
        case (fn)
            FN_PUSH_FRONT: begin
                if (n >= DEPTH) r.status = ST_FULL;
                else shadow_words.push_front(din);
            end
            FN_PUSH_BACK: begin
                if (n >= DEPTH) r.status = ST_FULL;
                else shadow_words.push_back(din);
            end
            FN_POP_FRONT: begin
                if (n == 0) r.status = ST_BAD;
                else r.data_out = shadow_words.pop_front();
            end
            FN_POP_BACK: begin
                if (n == 0) r.status = ST_BAD;
                else r.data_out = shadow_words.pop_back();
            end
            FN_INSERT: begin
                // index check takes priority over the full check
                if (pos > n) r.status = ST_BAD;
                else if (n >= DEPTH) r.status = ST_FULL;
                else shadow_words.insert(pos, din);
            end
            FN_REMOVE: begin
                if (pos >= n) r.status = ST_BAD;
                else begin
                    r.data_out = shadow_words[pos];
                    shadow_words.delete(pos);
                end
            end
            FN_READ: begin
                if (pos >= n) r.status = ST_BAD;
                else r.data_out = shadow_words[pos];
            end
            FN_CLEAR: shadow_words.delete();
            FN_REVERSE: shadow_words.reverse();
            default: r.status = ST_BAD;
        endcase
        r.occupancy = OCC_W'(shadow_words.size());
        if (shadow_words.size() > max_occ_seen) max_occ_seen = shadow_words.size();
        return r;
    endfunction

    // Drive one transaction and hold it until accepted; valid drops only when idling.
    task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [POS_W-1:0] pos,
                                input logic [31:0] din, input bit has_exp,
                                input t_idq_result exp);
        t_idq_result pred;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {5'd0, din, pos};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pred = predict_request(fn, pos, din);
        if (has_exp && pred != exp)
            $error("directed row disagrees with predictor: exp %h pred %h", exp, pred);
        pending_results.push_back(has_exp ? exp : pred);
        sent_count++;
        @(negedge i_clk);
    endtask

    function automatic t_idq_result mk(input logic [1:0] s, input logic [31:0] d,
                                       input int unsigned o);
        t_idq_result r;
        r.status = s;
        r.data_out = d;
        r.occupancy = OCC_W'(o);
        return r;
    endfunction

    // Pick a random request, weighted to keep the queue busy and hit edges.
    task automatic send_random;
        logic [FUNC_W-1:0] fn;
        logic [POS_W-1:0]  pos;
        int unsigned       n;
        int unsigned       pick;
        n = shadow_words.size();
        pick = $urandom_range(99);
        if (pick < 20)      fn = FN_PUSH_BACK;
        else if (pick < 35) fn = FN_PUSH_FRONT;
        else if (pick < 45) fn = FN_POP_FRONT;
        else if (pick < 55) fn = FN_POP_BACK;
        else if (pick < 68) fn = FN_INSERT;
        else if (pick < 78) fn = FN_REMOVE;
        else if (pick < 90) fn = FN_READ;
        else if (pick < 93) fn = FN_REVERSE;
        else if (pick < 95) fn = FN_CLEAR;
        else                fn = FUNC_W'($urandom_range(15));
        pick = $urandom_range(9);
        if (pick == 0)      pos = POS_W'($urandom());
        else if (pick == 1) pos = POS_W'(n);
        else if (n == 0)    pos = '0;
        else                pos = POS_W'($urandom_range(n - 1));
        send_request(fn, pos, $urandom(), 1'b0, '0);
    endtask

    // Drop valid and hold the sender until every expected result has come.
    task automatic wait_drained;
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    // Receiver: stall at random, check every accepted result in order.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_idq_result exp;
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_axis_tvalid && m_axis_tready) begin
                recv_count++;
                if (pending_results.size() == 0) begin
                    $error("result with no request outstanding: tdata %h", m_axis_tdata);
                    fail_count++;
                end else begin
                    exp = pending_results.pop_front();
                    if (m_axis_tuser !== exp.status) begin
                        $error("status: expected %0d, actual %0d", exp.status, m_axis_tuser);
                        fail_count++;
                    end
                    if (m_axis_tdata[31:0] !== exp.data_out) begin
                        $error("data_out: expected %h, actual %h",
                               exp.data_out, m_axis_tdata[31:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[42:32] !== exp.occupancy) begin
                        $error("occupancy: expected %0d, actual %0d",
                               exp.occupancy, m_axis_tdata[42:32]);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if (idle_cycles >= WD_MAX) begin
            $display("watchdog expired with %0d results outstanding", pending_results.size());
            $display("indexed_double_ended_queue_top regression: fail");
            $finish;
        end
    end

    t_idq_row directed_rows [$];

    task automatic add_row(input logic [FUNC_W-1:0] fn, input logic [POS_W-1:0] pos,
                           input logic [31:0] din, input bit has_exp, input t_idq_result exp);
        t_idq_row row;
        row.func = fn;
        row.position = pos;
        row.data_in = din;
        row.has_exp = has_exp;
        row.exp = exp;
        directed_rows.push_back(row);
    endtask

    initial begin
        int unsigned phase;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: empty-queue errors, extremes of fields, every request.
        add_row(FN_POP_FRONT, 11'd0, 32'h0, 1, mk(ST_BAD, 32'h0, 0));
        add_row(FN_POP_BACK, 11'd0, 32'h0, 1, mk(ST_BAD, 32'h0, 0));
        add_row(FN_READ, 11'd0, 32'h0, 1, mk(ST_BAD, 32'h0, 0));
        add_row(FN_REMOVE, 11'h7ff, 32'h0, 1, mk(ST_BAD, 32'h0, 0));
        add_row(FN_INSERT, 11'd1, 32'h1, 1, mk(ST_BAD, 32'h0, 0));
        add_row(FN_REVERSE, 11'd0, 32'h0, 1, mk(ST_OK, 32'h0, 0));
        add_row(FN_PUSH_BACK, 11'h7ff, 32'hffff_ffff, 1, mk(ST_OK, 32'h0, 1));
        add_row(FN_REVERSE, 11'd0, 32'h0, 1, mk(ST_OK, 32'h0, 1));
        add_row(FN_PUSH_FRONT, 11'd0, 32'h0, 1, mk(ST_OK, 32'h0, 2));
        add_row(FN_INSERT, 11'd1, 32'h5a5a_a5a5, 0, '0);
        add_row(FN_INSERT, 11'd3, 32'h1234_5678, 0, '0);
        add_row(FN_INSERT, 11'd0, 32'h8000_0001, 0, '0);
        add_row(FN_READ, 11'd2, 32'h0, 0, '0);
        add_row(FN_REVERSE, 11'd0, 32'h0, 0, '0);
        add_row(FN_REMOVE, 11'd1, 32'h0, 0, '0);
        add_row(FN_REMOVE, 11'd3, 32'h0, 0, '0);
        add_row(FN_READ, 11'd3, 32'h0, 1, mk(ST_BAD, 32'h0, 3));
        add_row(FN_POP_FRONT, 11'd0, 32'h0, 0, '0);
        add_row(4'd9, 11'd0, 32'h0, 1, mk(ST_BAD, 32'h0, 2));
        add_row(4'd15, 11'h7ff, 32'hffff_ffff, 1, mk(ST_BAD, 32'h0, 2));
        add_row(FN_POP_BACK, 11'd0, 32'h0, 0, '0);
        add_row(FN_REMOVE, 11'd0, 32'h0, 0, '0);
        add_row(FN_PUSH_BACK, 11'd0, 32'h0000_ffff, 1, mk(ST_OK, 32'h0, 1));
        add_row(FN_CLEAR, 11'd0, 32'h0, 1, mk(ST_OK, 32'h0, 0));
        foreach (directed_rows[i])
            send_request(directed_rows[i].func, directed_rows[i].position,
                         directed_rows[i].data_in, directed_rows[i].has_exp,
                         directed_rows[i].exp);

        // Hold the sender until the queue has caught up before going random.
        wait_drained();

        // Random requests over three idling phases.
        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 46 : 0;
            recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 21 : 0;
            for (int unsigned k = 0; k < N_RAND / 3; k++)
                send_random();
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Ran %0d requests, checked %0d results; peak occupancy %0d of %0d.",
                 sent_count, recv_count, max_occ_seen, DEPTH);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("indexed_double_ended_queue_top regression: pass");
        else
            $display("indexed_double_ended_queue_top regression: fail");
        $finish;
    end

endmodule
